### rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// Minimum coin change package
// Shared widths, sizes, reset values and command/status types for the
// controller and the datapath of the minimum coin change block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

   // Table depth and number of denominations consulted.
   localparam int MAX_AMOUNT = 1024;
   localparam int NUM_COINS  = 6;

   // Fixed field widths.
   localparam int AMOUNT_W   = 10;
   localparam int COIN_W     = 10;
   localparam int COUNT_W    = 11;

   // Register slots that exist on the configuration port.
   localparam int SLOT_COUNT = 6;
   localparam int CSR_IDX_W  = 3;

   // Derived sizes.
   localparam int ADDR_W     = $clog2(MAX_AMOUNT);
   localparam int SLOT_W     = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;

   typedef logic [COIN_W-1:0] coin_type;

   localparam coin_type COIN_RESET [SLOT_COUNT] = '{
      coin_type'(1), coin_type'(5), coin_type'(10),
      coin_type'(25), coin_type'(50), coin_type'(0)
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;   // latch a new amount, seed the table
      logic              issue;  // look up one denomination for the current amount
      logic              write;  // store the finished entry, step the amount
      logic [SLOT_W-1:0] slot;   // denomination slot being looked up
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic target_zero;  // the requested amount is zero
      logic at_target;    // the current amount is the requested one
   } status_type;

endpackage

`default_nettype wire

### rtl/mcc_ctrl.sv
// ----------------------------------------------------------------------------
// Minimum coin change controller
// State machine that walks the amounts and the denomination slots and
// raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   output mcc_pkg::cmd_type         cmd,
   input  wire mcc_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_WRITE
   } state_type;

   localparam logic [mcc_pkg::SLOT_W-1:0] LAST_SLOT =
      mcc_pkg::SLOT_W'(mcc_pkg::NUM_COINS - 1);

   state_type                   state_ff;
   logic [mcc_pkg::SLOT_W-1:0]  slot_ff;
   logic                        busy_ff;
   logic                        rsp_valid_ff;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && start;
      cmd.issue = (state_ff == ST_SCAN);
      cmd.write = (state_ff == ST_WRITE);
      cmd.slot  = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_PREP;
                  busy_ff  <= 1'b1;
               end
            end
            ST_PREP: begin
               if (status.target_zero) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_SCAN;
                  slot_ff  <= '0;
               end
            end
            ST_SCAN: begin
               if (slot_ff == LAST_SLOT) begin
                  state_ff <= ST_WRITE;
               end else begin
                  slot_ff <= slot_ff + 1'b1;
               end
            end
            ST_WRITE: begin
               slot_ff <= '0;
               if (status.at_target) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // A result strobe lasts a single cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // An accepted transaction makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted transaction did not raise busy");

   // The strobe only appears once the work is finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!busy_ff && state_ff == ST_IDLE))
      else $error("result strobe while still busy");

endmodule

`default_nettype wire

### rtl/mcc_datapath.sv
// ----------------------------------------------------------------------------
// Minimum coin change datapath
// Denomination registers, the best-count table memory, the running minimum
// and the amount counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [mcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcc_pkg::COIN_W-1:0]       csr_wdata,
   input  wire logic [mcc_pkg::AMOUNT_W-1:0]     req_amount,
   input  wire mcc_pkg::cmd_type                 cmd,
   output mcc_pkg::status_type                   status,
   output logic [mcc_pkg::COUNT_W-1:0]           rsp_coin_count
);

   mcc_pkg::coin_type              coin_ff [mcc_pkg::SLOT_COUNT];
   logic [mcc_pkg::ADDR_W-1:0]     target_ff;
   logic [mcc_pkg::ADDR_W-1:0]     target_in;
   logic [mcc_pkg::ADDR_W-1:0]     amt_ff;
   logic [mcc_pkg::COUNT_W-1:0]    best_ff;
   logic [mcc_pkg::COUNT_W-1:0]    result_ff;
   logic                           rd_valid_ff;
   logic [mcc_pkg::COUNT_W-1:0]    rd_data_ff;

   logic [mcc_pkg::COUNT_W-1:0]    table_mem [mcc_pkg::MAX_AMOUNT];

   mcc_pkg::coin_type              coin_sel;
   logic                           coin_used;
   logic [mcc_pkg::ADDR_W-1:0]     rd_addr;
   logic [mcc_pkg::COUNT_W-1:0]    best_min;
   logic [mcc_pkg::COUNT_W-1:0]    entry_val;
   logic                           wr_en;
   logic [mcc_pkg::ADDR_W-1:0]     wr_addr;
   logic [mcc_pkg::COUNT_W-1:0]    wr_data;

   // Amounts past the table are clamped to its last entry.
   always_comb begin
      if (32'(req_amount) >= 32'(mcc_pkg::MAX_AMOUNT)) begin
         target_in = mcc_pkg::ADDR_W'(mcc_pkg::MAX_AMOUNT - 1);
      end else begin
         target_in = mcc_pkg::ADDR_W'(req_amount);
      end
   end

   always_comb begin
      coin_sel  = coin_ff[cmd.slot];
      coin_used = (coin_sel != '0) && (32'(coin_sel) <= 32'(amt_ff));
      rd_addr   = mcc_pkg::ADDR_W'(32'(amt_ff) - 32'(coin_sel));
      best_min  = (rd_valid_ff && (rd_data_ff < best_ff)) ? rd_data_ff : best_ff;
      entry_val = best_min + 1'b1;
      wr_en     = cmd.load || cmd.write;
      wr_addr   = cmd.load ? '0 : amt_ff;
      wr_data   = cmd.load ? '0 : entry_val;
   end

   // Configuration registers; writes beyond the slot list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcc_pkg::SLOT_COUNT; i++) begin
            coin_ff[i] <= mcc_pkg::COIN_RESET[i];
         end
      end else if (csr_wr_en && (32'(csr_index) < 32'(mcc_pkg::SLOT_COUNT))) begin
         coin_ff[csr_index] <= csr_wdata;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue && coin_used;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= target_in;
         amt_ff    <= mcc_pkg::ADDR_W'(1);
         best_ff   <= mcc_pkg::COUNT_W'(2);
         result_ff <= '0;
      end else if (cmd.write) begin
         result_ff <= entry_val;
         amt_ff    <= amt_ff + 1'b1;
         best_ff   <= mcc_pkg::COUNT_W'(32'(amt_ff) + 2);
      end else if (cmd.issue) begin
         best_ff   <= best_min;
      end
   end

   always_comb begin
      status.target_zero = (target_ff == '0);
      status.at_target   = (amt_ff == target_ff);
   end

   assign rsp_coin_count = result_ff;

   // Step writes only fill entries from one up to the requested amount.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (amt_ff != '0 && amt_ff <= target_ff))
      else $error("table write outside the requested range");

   // A lookup never reaches the entry being built or above it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && coin_used) |-> (rd_addr < amt_ff))
      else $error("table lookup of an entry not yet built");

endmodule

`default_nettype wire

### rtl/min_coin_change_dp_top.sv
// ----------------------------------------------------------------------------
// Minimum coin change top level
// Gives the fewest coins that make a requested amount from up to six
// configurable denominations, by bottom-up dynamic programming.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// The block then builds a table of best coin counts for every amount from
// zero up to the requested one, one denomination lookup per clock cycle
// while scanning: six lookups on the table memory's single read port and
// then one write for each amount, with no lookups for an amount of zero.
// The result appears on rsp_coin_count for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take the value
// in that cycle. Busy falls in the same cycle, and a new transaction may
// be accepted there. Denominations are to be written through the csr_
// port only while the block is idle, which the block itself does not
// enforce; a denomination of zero leaves its slot unused. The table memory
// needs no clearing after reset, as every entry is rebuilt before it is
// read.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change_dp_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [mcc_pkg::AMOUNT_W-1:0]     req_amount,
   output logic                                  rsp_valid,
   output logic [mcc_pkg::COUNT_W-1:0]           rsp_coin_count,
   input  wire logic                             csr_wr_en,
   input  wire logic [mcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcc_pkg::COIN_W-1:0]       csr_wdata
);

   // Command and status between the controller and the datapath.
   mcc_pkg::cmd_type    cmd;
   mcc_pkg::status_type status;

   mcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   mcc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_amount     (req_amount),
      .cmd            (cmd),
      .status         (status),
      .rsp_coin_count (rsp_coin_count)
   );

endmodule

`default_nettype wire

### sim/min_coin_change_dp_top_test.sv
// ----------------------------------------------------------------------------
// Minimum coin change testbench
// Drives amounts into the coin change block under a series of denomination
// sets, predicts the fewest coin count for each accepted transaction and
// compares every result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module min_coin_change_dp_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   // Register map of the configuration port. Indexes six and seven exist on
   // the port but have no register behind them.
   typedef enum logic [mcc_pkg::CSR_IDX_W-1:0] {
      REG_COIN_0  = 3'd0,
      REG_COIN_1  = 3'd1,
      REG_COIN_2  = 3'd2,
      REG_COIN_3  = 3'd3,
      REG_COIN_4  = 3'd4,
      REG_COIN_5  = 3'd5,
      REG_SPARE_6 = 3'd6,
      REG_SPARE_7 = 3'd7
   } csr_reg_type;

   // SLOWEST_ITEM is the slowest transaction; the limit covers every
   // transaction taking that long plus the sender's gaps, several times over.
   localparam int unsigned SLOWEST_ITEM   = 2 + 7 * (mcc_pkg::MAX_AMOUNT - 1);
   localparam int unsigned TIMEOUT_CYCLES = 4_000_000;
   localparam int unsigned RANDOM_PHASES  = 5;
   localparam int unsigned PHASE_ITEMS    = 16;
   localparam int unsigned REPORT_LIMIT   = 10;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [mcc_pkg::AMOUNT_W-1:0]        req_amount = '0;
   logic                                rsp_valid;
   logic [mcc_pkg::COUNT_W-1:0]         rsp_coin_count;
   logic                                csr_wr_en = 1'b0;
   logic [mcc_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [mcc_pkg::COIN_W-1:0]          csr_wdata = '0;

   // Testbench copy of the denomination registers, kept in step with every
   // write that the configuration port performs.
   mcc_pkg::coin_type    coin_set [mcc_pkg::SLOT_COUNT] = mcc_pkg::COIN_RESET;

   // Predicted coin counts, oldest first, one per accepted transaction.
   logic [mcc_pkg::COUNT_W-1:0]         pending_counts [$];

   int unsigned          items_sent    = 0;
   int unsigned          results_taken = 0;
   int unsigned          failures      = 0;
   int unsigned          coin_sets     = 1;
   int unsigned          cycle_count   = 0;
   int unsigned          idle_pct      = 9;
   logic [mcc_pkg::COUNT_W-1:0]         want;

   min_coin_change_dp_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_coin_count (rsp_coin_count),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bottom-up table of best counts from zero to the requested amount. An
   // amount that cannot be made ends up at most at amount + 2.
   function automatic logic [mcc_pkg::COUNT_W-1:0] fewest_coins(
         input logic [mcc_pkg::AMOUNT_W-1:0] amount);
      logic [mcc_pkg::COUNT_W-1:0] best_count [mcc_pkg::MAX_AMOUNT];
      int unsigned        target;
      int unsigned        best;
      int unsigned        denom;
      target = amount;
      if (target >= mcc_pkg::MAX_AMOUNT) begin
         target = mcc_pkg::MAX_AMOUNT - 1;
      end
      best_count[0] = '0;
      for (int unsigned c = 1; c <= target; c++) begin
         best = c + 1;
         for (int k = 0; k < mcc_pkg::NUM_COINS && k < mcc_pkg::SLOT_COUNT; k++) begin
            denom = coin_set[k];
            // Unused slots hold zero and are skipped.
            if (denom != 0 && denom <= c && best_count[c - denom] < best) begin
               best = best_count[c - denom];
            end
         end
         best_count[c] = mcc_pkg::COUNT_W'(best + 1);
      end
      return best_count[target];
   endfunction

   // Mostly small amounts, since the block builds a table entry for every unit
   // of amount; a few reach towards the top of the range.
   function automatic logic [mcc_pkg::AMOUNT_W-1:0] random_amount();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         return mcc_pkg::AMOUNT_W'($urandom_range(0, 63));
      end else if (pick < 95) begin
         return mcc_pkg::AMOUNT_W'($urandom_range(64, 255));
      end else begin
         return mcc_pkg::AMOUNT_W'($urandom_range(256, mcc_pkg::MAX_AMOUNT - 1));
      end
   endfunction

   // A denomination is sometimes unused, sometimes anywhere in its range and
   // usually small enough that the table is full of interesting choices.
   function automatic mcc_pkg::coin_type random_coin();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         return '0;
      end else if (pick < 30) begin
         return mcc_pkg::coin_type'($urandom_range(0, 1023));
      end else begin
         return mcc_pkg::coin_type'($urandom_range(1, 40));
      end
   endfunction

   // Offers one amount and waits until the block accepts it. Start is left
   // high on return so that back-to-back transactions need no gap; whoever
   // stops sending lowers it.
   task automatic send_amount(input logic [mcc_pkg::AMOUNT_W-1:0] amount);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_amount <= amount;
      do @(posedge clock); while (busy !== 1'b0);
      pending_counts.push_back(fewest_coins(amount));
      items_sent++;
   endtask

   // Stops sending and waits until every accepted transaction has produced
   // its result. Every transaction gives exactly one result, so the block is
   // idle once the count of results taken has caught up.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (results_taken < items_sent);
   endtask

   // One register write. The write enable is left high; the caller lowers it
   // after the last write of a batch.
   task automatic csr_write(input csr_reg_type which, input mcc_pkg::coin_type value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      if (which < mcc_pkg::SLOT_COUNT) begin
         coin_set[which] = value;
      end
   endtask

   task automatic program_coins(input mcc_pkg::coin_type c0, input mcc_pkg::coin_type c1,
                                input mcc_pkg::coin_type c2, input mcc_pkg::coin_type c3,
                                input mcc_pkg::coin_type c4, input mcc_pkg::coin_type c5);
      wait_idle();
      csr_write(REG_COIN_0, c0);
      csr_write(REG_COIN_1, c1);
      csr_write(REG_COIN_2, c2);
      csr_write(REG_COIN_3, c3);
      csr_write(REG_COIN_4, c4);
      csr_write(REG_COIN_5, c5);
      csr_wr_en <= 1'b0;
      coin_sets++;
   endtask

   // The denominations left by reset, with the amount range covered at both
   // ends and every amount bit taking both values.
   task automatic test_reset_denominations();
      send_amount(10'd0);
      send_amount(10'd1);
      send_amount(10'd4);
      send_amount(10'd5);
      send_amount(10'd30);
      send_amount(10'd99);
      send_amount(10'h155);
      send_amount(10'h2AA);
      send_amount(10'h3FF);
   endtask

   // With every slot unused nothing can be made, so each count comes out two
   // above the amount, and zero for an amount of zero.
   task automatic test_unmakeable_amounts();
      program_coins(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      send_amount(10'd0);
      send_amount(10'd1);
      send_amount(10'h3FF);
   endtask

   // Repeated denominations and unused slots mixed together; an amount of
   // three cannot be made from fours and nines.
   task automatic test_duplicate_and_unused_slots();
      program_coins(10'd4, 10'd4, 10'd0, 10'd9, 10'd9, 10'd0);
      send_amount(10'd3);
      send_amount(10'd4);
      send_amount(10'd13);
      send_amount(10'd17);
      send_amount(10'd0);
   endtask

   // Writes to the indexes with no register behind them must change nothing.
   task automatic test_spare_register_writes();
      wait_idle();
      csr_write(REG_SPARE_6, 10'h3FF);
      csr_write(REG_SPARE_7, 10'h2AA);
      csr_wr_en <= 1'b0;
      send_amount(10'd8);
      send_amount(10'd18);
   endtask

   // Every slot at the largest denomination: only the top amount is makeable.
   task automatic test_largest_denominations();
      program_coins(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
      send_amount(10'h3FF);
      send_amount(10'h3FE);
   endtask

   // Several random denomination sets, each followed by a burst of random
   // amounts. One burst runs with the sender never pausing.
   task automatic test_random_sets();
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_coins(random_coin(), random_coin(), random_coin(),
                       random_coin(), random_coin(), random_coin());
         idle_pct = (phase == 2) ? 0 : 9;
         repeat (PHASE_ITEMS) begin
            send_amount(random_amount());
         end
      end
      idle_pct = 9;
   endtask

   task automatic record_failure(input string what);
      if (failures < REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, what);
      end
      failures++;
   endtask

   // Result checker. The strobe lasts one cycle and cannot be held off, so
   // every rising edge with the strobe high carries a transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_counts.size() == 0) begin
            record_failure($sformatf("unexpected result: coin_count %0d", rsp_coin_count));
         end else begin
            want = pending_counts.pop_front();
            if (rsp_coin_count !== want) begin
               record_failure($sformatf("coin_count mismatch: expected %0d, got %0d",
                                        want, rsp_coin_count));
            end
         end
         results_taken <= results_taken + 1;
      end
   end

   // Guard against a hang: the run is abandoned well beyond its slowest
   // correct length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_counts.size());
         $display("min_coin_change_dp_top_test: errors");
         $finish;
      end
   end

   initial begin
      // Synchronous reset held from the start, then released for good.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_denominations();
      test_unmakeable_amounts();
      test_duplicate_and_unused_slots();
      test_spare_register_writes();
      test_largest_denominations();
      test_random_sets();

      // Let every outstanding transaction finish, then watch a while longer
      // for any stray result strobe.
      wait_idle();
      repeat (SLOWEST_ITEM) @(posedge clock);
      if (pending_counts.size() != 0) begin
         record_failure($sformatf("%0d predicted results never arrived",
                                  pending_counts.size()));
      end

      $display("Covered %0d amounts over %0d denomination sets; %0d results compared.",
               items_sent, coin_sets, results_taken);
      $display("Failures recorded: %0d.", failures);
      if (failures == 0) begin
         $display("min_coin_change_dp_top_test: clean");
      end else begin
         $display("min_coin_change_dp_top_test: errors");
      end
      $finish;
   end

endmodule
